@@ hdl/frequency_ordered_list_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the frequency ordered list
// Concurrent checks that drop out when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef FREQUENCY_ORDERED_LIST_MACROS_SVH
`define FREQUENCY_ORDERED_LIST_MACROS_SVH

`ifndef SYNTHESIS

// Plain property, checked on every rising edge outside reset.
`define FOL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Same-cycle implication.
`define FOL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define FOL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`else

`define FOL_ASSERT(lbl, clk, rstn, prop, msg)
`define FOL_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define FOL_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hdl/fol_pkg.sv @@
// ----------------------------------------------------------------------------
// fol_pkg
// Shared constants, types and controller/datapath interface structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fol_pkg;

  localparam int DEPTH      = 16;               // table entries, 2..16 (position_o is POS_W = 4 bits)
  localparam int KEY_W      = 16;               // stored key bits, 1..64
  localparam int KEY_PORT_W = 16;
  localparam int COUNT_W    = 16;
  localparam int POS_W      = 4;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int USED_W     = $clog2(DEPTH + 1);

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_LOCATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FIND,
    ST_MOVE
  } fol_state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;   // capture the request
    logic find;   // append, or search the row
    logic move;   // promote the hit entry
  } fol_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic locate;
    logic hit;
  } fol_sts_t;

endpackage

@@ hdl/fol_ctrl.sv @@
// ----------------------------------------------------------------------------
// fol_ctrl
// Sequencer: capture, find/append, then move on a locate hit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fol_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  output fol_pkg::fol_cmd_t cmd_o,
  input  fol_pkg::fol_sts_t sts_i
);
  import fol_pkg::*;

  fol_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_FIND;
        end
      end
      ST_FIND: begin
        cmd_o.find = 1'b1;
        if (sts_i.locate && sts_i.hit) begin
          state_d = ST_MOVE;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_MOVE: begin
        cmd_o.move = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

@@ hdl/fol_dp.sv @@
// ----------------------------------------------------------------------------
// fol_dp
// Row of key/count cells with parallel compare, shift-down promotion and
// registered result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fol_dp (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  fol_pkg::fol_cmd_t            cmd_i,
  output fol_pkg::fol_sts_t            sts_o,
  input  logic                         action_i,
  input  logic [fol_pkg::KEY_PORT_W-1:0] key_i,
  output logic                         done_o,
  output logic                         found_o,
  output logic [fol_pkg::POS_W-1:0]    position_o,
  output logic [fol_pkg::COUNT_W-1:0]  access_count_o,
  output logic                         table_full_o
);
  import fol_pkg::*;

  logic                act_q;
  logic [KEY_W-1:0]    key_q;
  logic [KEY_W-1:0]    keys_q   [DEPTH];
  logic [KEY_W-1:0]    keys_d   [DEPTH];
  logic [COUNT_W-1:0]  counts_q [DEPTH];
  logic [COUNT_W-1:0]  counts_d [DEPTH];
  logic [USED_W-1:0]   used_q, used_d;
  logic [IDX_W-1:0]    hit_idx_q, hit_idx_d;
  logic [COUNT_W-1:0]  cnt_q, cnt_d;

  logic                done_q, done_d;
  logic                found_q, found_d;
  logic [POS_W-1:0]    pos_q, pos_d;
  logic [COUNT_W-1:0]  acc_q, acc_d;
  logic                full_q, full_d;

  logic [DEPTH-1:0]    match;
  logic                hit_any;
  logic [IDX_W-1:0]    hit_idx;
  logic [IDX_W-1:0]    dest;
  logic [COUNT_W-1:0]  hit_cnt;
  logic                tbl_full;

  // parallel compare over the valid part of the row, first match wins
  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match[i] = (USED_W'(i) < used_q) && (keys_q[i] == key_q);
    end
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match[i]) hit_idx = IDX_W'(i);
    end
  end

  assign hit_any  = |match;
  assign hit_cnt  = counts_q[hit_idx];
  assign tbl_full = (used_q == USED_W'(DEPTH));

  // counts are kept non-increasing, so the first entry at or below the new
  // count is where the hit lands
  always_comb begin
    dest = hit_idx_q;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if ((IDX_W'(i) < hit_idx_q) && (counts_q[i] <= cnt_q)) dest = IDX_W'(i);
    end
  end

  assign sts_o.locate = act_q;
  assign sts_o.hit    = hit_any;

  always_comb begin
    keys_d    = keys_q;
    counts_d  = counts_q;
    used_d    = used_q;
    hit_idx_d = hit_idx_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    found_d   = found_q;
    pos_d     = pos_q;
    acc_d     = acc_q;
    full_d    = full_q;

    if (cmd_i.find) begin
      if (act_q == ACT_APPEND) begin
        done_d  = 1'b1;
        found_d = 1'b0;
        acc_d   = '0;
        if (tbl_full) begin
          full_d = 1'b1;
          pos_d  = '0;
        end else begin
          full_d                     = 1'b0;
          pos_d                      = POS_W'(used_q);
          keys_d[IDX_W'(used_q)]     = key_q;
          counts_d[IDX_W'(used_q)]   = '0;
          used_d                     = used_q + USED_W'(1);
        end
      end else if (hit_any) begin
        hit_idx_d = hit_idx;
        cnt_d     = (hit_cnt == COUNT_MAX) ? hit_cnt : hit_cnt + COUNT_W'(1);
      end else begin
        // locate miss
        done_d  = 1'b1;
        found_d = 1'b0;
        pos_d   = '0;
        acc_d   = '0;
        full_d  = 1'b0;
      end
    end

    if (cmd_i.move) begin
      for (int i = 1; i < DEPTH; i++) begin
        if ((IDX_W'(i) > dest) && (IDX_W'(i) <= hit_idx_q)) begin
          keys_d[i]   = keys_q[i-1];
          counts_d[i] = counts_q[i-1];
        end
      end
      keys_d[dest]   = key_q;
      counts_d[dest] = cnt_q;
      done_d  = 1'b1;
      found_d = 1'b1;
      pos_d   = POS_W'(dest);
      acc_d   = cnt_q;
      full_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= '0;
      done_q <= 1'b0;
      for (int i = 0; i < DEPTH; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      used_q   <= used_d;
      done_q   <= done_d;
      counts_q <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q <= action_i;
      key_q <= KEY_W'(key_i);
    end
    keys_q    <= keys_d;
    hit_idx_q <= hit_idx_d;
    cnt_q     <= cnt_d;
    found_q   <= found_d;
    pos_q     <= pos_d;
    acc_q     <= acc_d;
    full_q    <= full_d;
  end

  assign done_o         = done_q;
  assign found_o        = found_q;
  assign position_o     = pos_q;
  assign access_count_o = acc_q;
  assign table_full_o   = full_q;

endmodule

@@ hdl/frequency_ordered_list.sv @@
// ----------------------------------------------------------------------------
// frequency_ordered_list
// Self-organising key table ordered by access count, most recently located
// first among equal counts; new keys join the tail with count zero.
// ----------------------------------------------------------------------------
// Usage:
//   A request (action_i, key_i) is taken on a rising edge with start high and
//   busy low. action_i low appends key_i at the tail with count zero; high
//   locates key_i, bumps its saturating count and promotes the entry.
//   Each request gives exactly one result, shown on found_o, position_o,
//   access_count_o and table_full_o for one cycle while done_o is high.
//   Sequence: append or locate miss - the request is registered, the FIND
//   state appends or compares, and done_o and the result are registered
//   from it; locate hit - a MOVE state follows FIND for the shift of the
//   cell row. busy is high in FIND and MOVE and low again while the result
//   is shown, so a new request can be taken in the cycle its predecessor's
//   result is shown. A new request is not taken before then, since busy
//   covers the compare and the promotion over the register row.
//   Reset empties the table and clears all counts at once; no sweep.
//   The receiver cannot stall: results must be taken when done_o is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module frequency_ordered_list (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic                           action_i,
  input  logic [fol_pkg::KEY_PORT_W-1:0] key_i,
  output logic                           done_o,
  output logic                           found_o,
  output logic [fol_pkg::POS_W-1:0]      position_o,
  output logic [fol_pkg::COUNT_W-1:0]    access_count_o,
  output logic                           table_full_o
);
  import fol_pkg::*;

  fol_cmd_t cmd;
  fol_sts_t sts;

  fol_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  fol_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .action_i       (action_i),
    .key_i          (key_i),
    .done_o         (done_o),
    .found_o        (found_o),
    .position_o     (position_o),
    .access_count_o (access_count_o),
    .table_full_o   (table_full_o)
  );

`include "frequency_ordered_list_macros.svh"

  `FOL_ASSERT_IMP(a_done_after_busy, clk_i, rst_ni, done_o, $past(busy), "result without busy work")
  `FOL_ASSERT_NXT(a_accept_busy, clk_i, rst_ni, start && !busy, busy, "accepted request not worked")
  `FOL_ASSERT_IMP(a_full_no_hit, clk_i, rst_ni, done_o && table_full_o, !found_o, "full flag on hit")
  `FOL_ASSERT_IMP(a_hit_count, clk_i, rst_ni, done_o && found_o, access_count_o != '0, "zero count on hit")

endmodule
